/* rtl/embedding_distance_unit_assert.svh */
// Assertion macros shared by the embedding distance unit RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef EMBEDDING_DISTANCE_UNIT_ASSERT_SVH
`define EMBEDDING_DISTANCE_UNIT_ASSERT_SVH

// Same-cycle implication
`define EDU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("edu check failed");

// Next-cycle implication
`define EDU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("edu check failed");

`endif

/* rtl/edu_pkg.sv */
// Package for the embedding distance unit: widths, codes, command types.
// No dependencies.
`default_nettype none
package edu_pkg;
  localparam int unsigned MaxVecLen  = 128;
  localparam int unsigned SumW       = 40;
  localparam int unsigned DiffSumW   = 42;
  localparam int unsigned DistW      = 48;
  localparam int unsigned SqrtSteps  = 32;
  localparam int unsigned DivSteps   = 89;
  localparam int unsigned StepCntW   = 7;

  localparam logic [1:0] ModeCosine = 2'd0;
  localparam logic [1:0] ModeEuclid = 2'd1;
  localparam logic [1:0] ModeNormSq = 2'd2;

  typedef struct packed {
    logic       clr;
    logic       acc_en;
    logic       sqrt_start;
    logic       sqrt_step;
    logic       mul_div_start;
    logic       div_step;
    logic       load_out;
    logic [1:0] mode;
  } edu_cmd_t;
endpackage
`default_nettype wire

/* rtl/edu_if.sv */
// Handshake interfaces of the embedding distance unit: input item,
// result item and configuration write. Widths are written out, not taken from edu_pkg.
`default_nettype none
interface edu_item_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] elem_a;
  logic signed [15:0] elem_b;
  logic               last_elem;
  modport source (output valid, elem_a, elem_b, last_elem, input ready);
  modport sink (input valid, elem_a, elem_b, last_elem, output ready);
endinterface

interface edu_res_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] distance;
  logic               bad_input;
  modport source (output valid, distance, bad_input, input ready);
  modport sink (input valid, distance, bad_input, output ready);
endinterface

interface edu_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

/* rtl/embedding_distance_unit.sv */
// Top level of the embedding distance unit: controller plus datapath.
// Depends on edu_pkg, edu_if, edu_ctrl and edu_datapath.
//
//   channel   dir  handshake      payload
//   item_i    in   valid/ready    elem_a, elem_b, last_elem
//   result_o  out  valid/ready    distance, bad_input
//   cfg_i     in   valid/ready    data (metric_mode)
//
// Element pairs are taken one per cycle while accumulating.
// After the last pair, euclidean mode or an unused selector goes straight to StFin;
// the cosine modes first run the 32-step bit-serial square roots and the
// 89-step one-bit-per-cycle divider.
// A finished result waits in the output register while the next vector streams in.
// Asynchronous active-low reset clears the sums, the sequencer and metric_mode.
`default_nettype none
module embedding_distance_unit #(
  parameter int unsigned MAX_VEC_LEN = edu_pkg::MaxVecLen
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  edu_item_if.sink    item_i,
  edu_res_if.source   result_o,
  edu_cfg_if.sink     cfg_i
);
  import edu_pkg::*;

  edu_cmd_t cmd;

  edu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_last_i   (item_i.last_elem),
    .in_ready_o  (item_i.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  edu_datapath #(
    .MAX_VEC_LEN (MAX_VEC_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .elem_a_i    (item_i.elem_a),
    .elem_b_i    (item_i.elem_b),
    .distance_o  (result_o.distance),
    .bad_input_o (result_o.bad_input)
  );
endmodule
`default_nettype wire

/* rtl/edu_ctrl.sv */
// Controller of the embedding distance unit: sequencer, step counter,
// metric register and result valid. Depends on edu_pkg and the assert header.
`default_nettype none
`include "embedding_distance_unit_assert.svh"
module edu_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_last_i,
  output logic                    in_ready_o,
  input  wire logic               cfg_valid_i,
  input  wire logic [1:0]         cfg_data_i,
  output logic                    cfg_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output edu_pkg::edu_cmd_t       cmd_o
);
  import edu_pkg::*;

  typedef enum logic [5:0] {
    StAcc  = 6'b000001,
    StPrep = 6'b000010,
    StSqrt = 6'b000100,
    StMul  = 6'b001000,
    StDiv  = 6'b010000,
    StFin  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [StepCntW-1:0]  cnt_q, cnt_d;
  logic [1:0]           mode_q;
  logic                 out_valid_q, out_valid_d;
  logic                 in_fire, slot_free;

  assign in_ready_o  = (state_q == StAcc);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;

  // metric register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeCosine;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    cmd_o.mode  = mode_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StAcc: begin
        cmd_o.acc_en = in_fire;
        if (in_fire && in_last_i) begin
          if (mode_q == ModeCosine || mode_q == ModeNormSq) begin
            state_d = StPrep;
          end else begin
            state_d = StFin;
          end
        end
      end
      StPrep: begin
        cmd_o.sqrt_start = 1'b1;
        cnt_d   = StepCntW'(SqrtSteps - 1);
        state_d = StSqrt;
      end
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StMul;
        end
      end
      StMul: begin
        cmd_o.mul_div_start = 1'b1;
        cnt_d   = StepCntW'(DivSteps - 1);
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.clr      = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StAcc;
        end
      end
      default: begin
        state_d = StAcc;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StAcc;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `EDU_ASSERT_NEXT(a_cos_starts_prep,
    in_fire && in_last_i && (mode_q == ModeCosine || mode_q == ModeNormSq), state_q == StPrep)
  `EDU_ASSERT_NEXT(a_fin_holds, state_q == StFin && !slot_free, state_q == StFin)
  `EDU_ASSERT_NEXT(a_div_ends, state_q == StDiv && cnt_q == '0, state_q == StFin)
endmodule
`default_nettype wire

/* rtl/edu_datapath.sv */
// Datapath of the embedding distance unit: accumulators, two bit-serial
// square roots, a denominator multiplier, restoring divider, result register. Uses edu_pkg.
`default_nettype none
module edu_datapath #(
  parameter int unsigned MAX_VEC_LEN = edu_pkg::MaxVecLen
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire edu_pkg::edu_cmd_t         cmd_i,
  input  wire logic signed [15:0]        elem_a_i,
  input  wire logic signed [15:0]        elem_b_i,
  output logic signed [edu_pkg::DistW-1:0] distance_o,
  output logic                           bad_input_o
);
  import edu_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_VEC_LEN + 1);

  function automatic logic [66:0] sqrt_step(input logic [34:0] rem,
                                            input logic [31:0] root,
                                            input logic [1:0]  pair);
    logic [34:0] remx;
    logic [34:0] trial;
    remx  = {rem[32:0], pair};
    trial = {1'b0, root, 2'b01};
    if (remx >= trial) begin
      sqrt_step = {remx - trial, root[30:0], 1'b1};
    end else begin
      sqrt_step = {remx, root[30:0], 1'b0};
    end
  endfunction

  logic signed [SumW-1:0]     dot_q, na_q, nb_q;
  logic [DiffSumW-1:0]        dsq_q;
  logic [CntW-1:0]            count_q;
  logic                       ovf_q;
  logic signed [31:0]         p_ab, p_aa, p_bb;
  logic signed [16:0]         diff;
  logic signed [33:0]         p_dd;

  // per-pair products
  assign p_ab = elem_a_i * elem_b_i;
  assign p_aa = elem_a_i * elem_a_i;
  assign p_bb = elem_b_i * elem_b_i;
  assign diff = {elem_a_i[15], elem_a_i} - {elem_b_i[15], elem_b_i};
  assign p_dd = diff * diff;

  // accumulators and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0; na_q <= '0; nb_q <= '0; dsq_q <= '0;
      count_q <= '0; ovf_q <= 1'b0;
    end else if (cmd_i.clr) begin
      dot_q <= '0; na_q <= '0; nb_q <= '0; dsq_q <= '0;
      count_q <= '0; ovf_q <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (count_q < CntW'(MAX_VEC_LEN)) begin
        dot_q   <= dot_q + {{(SumW-32){p_ab[31]}}, p_ab};
        na_q    <= na_q + {{(SumW-32){p_aa[31]}}, p_aa};
        nb_q    <= nb_q + {{(SumW-32){p_bb[31]}}, p_bb};
        dsq_q   <= dsq_q + {{(DiffSumW-34){1'b0}}, p_dd[33:0]};
        count_q <= count_q + 1'b1;
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // square roots of norm << 24, two bits of radicand per cycle
  logic [63:0] rad_a_q, rad_b_q;
  logic [34:0] rem_a_q, rem_b_q;
  logic [31:0] root_a_q, root_b_q;
  logic [66:0] sa_nx, sb_nx;

  assign sa_nx = sqrt_step(rem_a_q, root_a_q, rad_a_q[63:62]);
  assign sb_nx = sqrt_step(rem_b_q, root_b_q, rad_b_q[63:62]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rad_a_q  <= {na_q, 24'd0};
      rad_b_q  <= {nb_q, 24'd0};
      rem_a_q  <= '0; rem_b_q  <= '0;
      root_a_q <= '0; root_b_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_a_q  <= {rad_a_q[61:0], 2'b00};
      rad_b_q  <= {rad_b_q[61:0], 2'b00};
      rem_a_q  <= sa_nx[66:32];
      root_a_q <= sa_nx[31:0];
      rem_b_q  <= sb_nx[66:32];
      root_b_q <= sb_nx[31:0];
    end
  end

  // denominator product and restoring division, one quotient bit per cycle
  logic [63:0] den_q, q_q;
  logic [88:0] num_q;
  logic [64:0] r_q, r_sh;
  logic [SumW-1:0] mag;

  assign mag  = dot_q[SumW-1] ? SumW'(-dot_q) : SumW'(dot_q);
  assign r_sh = {r_q[63:0], num_q[88]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_div_start) begin
      den_q <= root_a_q * root_b_q;
      num_q <= {mag, 49'd0};
      r_q   <= '0;
      q_q   <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[87:0], 1'b0};
      if (r_sh >= {1'b0, den_q}) begin
        r_q <= r_sh - {1'b0, den_q};
        q_q <= {q_q[62:0], 1'b1};
      end else begin
        r_q <= r_sh;
        q_q <= {q_q[62:0], 1'b0};
      end
    end
  end

  // metric selection, rounding and clamping
  localparam logic signed [50:0] DistMax = 51'sd140737488355327;
  localparam logic signed [50:0] DistMin = -51'sd140737488355328;

  logic [63:0]         qh;
  logic [46:0]         qc;
  logic signed [48:0]  cosv;
  logic signed [50:0]  nsq;
  logic [DiffSumW:0]   eu;
  logic                zero_norm;
  logic [DistW-1:0]    dist_d;
  logic                bad_d;

  always_comb begin
    qh   = 64'((65'(q_q) + 65'd1) >> 1);
    qc   = (qh > 64'(DistMax)) ? 47'h7FFF_FFFF_FFFF : qh[46:0];
    cosv = dot_q[SumW-1] ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
    nsq  = 51'sd33554432 - $signed({cosv[48], cosv, 1'b0});
    eu   = ({1'b0, dsq_q} + (DiffSumW+1)'(2)) >> 2;
    zero_norm = (na_q == '0) || (nb_q == '0);
    bad_d  = ovf_q;
    dist_d = '0;
    case (cmd_i.mode)
      ModeEuclid: begin
        dist_d = DistW'(eu);
      end
      ModeCosine: begin
        if (zero_norm) begin
          bad_d = 1'b1;
        end else begin
          dist_d = cosv[DistW-1:0];
        end
      end
      ModeNormSq: begin
        if (zero_norm) begin
          bad_d = 1'b1;
        end else if (nsq > DistMax) begin
          dist_d = DistMax[DistW-1:0];
        end else if (nsq < DistMin) begin
          dist_d = DistMin[DistW-1:0];
        end else begin
          dist_d = nsq[DistW-1:0];
        end
      end
      default: begin
        bad_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      distance_o  <= $signed(dist_d);
      bad_input_o <= bad_d;
    end
  end
endmodule
`default_nettype wire

/* dv/edu_sb.sv */
// Scoreboard for the embedding distance unit testbench: predicts each
// vector's metric from the accepted element pairs. Depends on edu_pkg.
package edu_sb_pkg;
  import edu_pkg::*;

  typedef struct {
    logic signed [47:0] distance;
    logic               bad_input;
  } dist_res_t;

  class dist_scoreboard;
    logic [1:0]         mode;
    longint             dot_acc, na_acc, nb_acc, dsq_acc;
    int unsigned        pair_cnt;
    bit                 len_over;
    dist_res_t          pending[$];
    int                 errors;

    function new();
      mode = ModeCosine;
      errors = 0;
      clear();
    endfunction

    function void clear();
      dot_acc = 0; na_acc = 0; nb_acc = 0; dsq_acc = 0;
      pair_cnt = 0; len_over = 0;
    endfunction

    // Integer square root, floor
    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Cosine in Q.24, rounded half away from zero
    function longint cosine_q24();
      longint unsigned sa, sb, den, mag;
      logic [127:0] num, q;
      sa = int_sqrt(64'(na_acc) << 24);
      sb = int_sqrt(64'(nb_acc) << 24);
      den = sa * sb;
      mag = dot_acc < 0 ? 64'(-dot_acc) : 64'(dot_acc);
      num = 128'(mag) << 49;
      q = num / 128'(den);
      q = (q + 1) >> 1;
      if (q > 128'h7FFF_FFFF_FFFF) q = 128'h7FFF_FFFF_FFFF;
      return dot_acc < 0 ? -longint'(q) : longint'(q);
    endfunction

    function void note_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
      longint sa, sb, d, dist_v, c;
      dist_res_t r;
      sa = a; sb = b;
      if (pair_cnt < MaxVecLen) begin
        d = sa - sb;
        dot_acc += sa * sb;
        na_acc += sa * sa;
        nb_acc += sb * sb;
        dsq_acc += d * d;
        pair_cnt++;
      end else begin
        len_over = 1;
      end
      if (!last) return;
      r.bad_input = len_over;
      dist_v = 0;
      if (mode == ModeEuclid) begin
        dist_v = (dsq_acc + 2) >>> 2;
      end else if (mode == ModeCosine || mode == ModeNormSq) begin
        if (na_acc == 0 || nb_acc == 0) begin
          r.bad_input = 1;
        end else begin
          c = cosine_q24();
          dist_v = (mode == ModeCosine) ? c : 2 * 64'sd16777216 - 2 * c;
        end
      end else begin
        r.bad_input = 1;
      end
      if (dist_v > 64'sh7FFF_FFFF_FFFF) dist_v = 64'sh7FFF_FFFF_FFFF;
      if (dist_v < -64'sh8000_0000_0000) dist_v = -64'sh8000_0000_0000;
      r.distance = dist_v[47:0];
      pending.push_back(r);
      clear();
    endfunction

    function void check_result(logic signed [47:0] distance, logic bad_input);
      dist_res_t e;
      if (pending.size() == 0) begin
        $error("result with no vector pending: distance %0d", distance);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (distance !== e.distance) begin
        $error("distance: expected %0d, actual %0d", e.distance, distance);
        errors++;
      end
      if (bad_input !== e.bad_input) begin
        $error("bad_input: expected %0d, actual %0d", e.bad_input, bad_input);
        errors++;
      end
    endfunction
  endclass
endpackage

/* dv/tb_embedding_distance_unit.sv */
// Top of the embedding distance unit testbench: clock, reset, drivers,
// receiver stalls and watchdog. Depends on edu_pkg, edu_if and edu_sb_pkg.
module tb_embedding_distance_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import edu_pkg::*;
  import edu_sb_pkg::*;

  localparam int IdleLimit = 20000;

  logic clk_i = 0;
  logic rst_ni = 0;
  edu_item_if item_if();
  edu_res_if  res_if();
  edu_cfg_if  cfg_if();
  dist_scoreboard sb;
  int idle_cycles;
  bit stim_done;
  int burst_left;

  embedding_distance_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .item_i(item_if.sink), .result_o(res_if.source), .cfg_i(cfg_if.sink)
  );

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  initial begin
    item_if.valid = 0; item_if.elem_a = 0; item_if.elem_b = 0; item_if.last_elem = 0;
    cfg_if.valid = 0; cfg_if.data = 0; res_if.ready = 0;
    sb = new();
  end

  // Receiver: stall pattern with long ready stretches
  always @(posedge clk_i) begin
    if ($urandom_range(0, 3) == 0) res_if.ready <= ($urandom_range(0, 4) != 0);
    else if ($urandom_range(0, 9) == 0) res_if.ready <= $urandom_range(0, 1);
  end

  // Result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) sb.check_result(res_if.distance, res_if.bad_input);
      if ((res_if.valid && res_if.ready) || (item_if.valid && item_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Stop the sender, drain every result, then write the metric
  task automatic write_mode(logic [1:0] m);
    item_if.valid <= 0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (140) @(posedge clk_i);
    cfg_if.valid <= 1;
    cfg_if.data <= m;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.mode = m;
    cfg_if.valid <= 0;
  endtask

  // One pair; random gap or burst continuation first
  task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    if (burst_left == 0) begin
      item_if.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    item_if.valid <= 1;
    item_if.elem_a <= a;
    item_if.elem_b <= b;
    item_if.last_elem <= last;
    do @(posedge clk_i); while (!item_if.ready);
    sb.note_pair(a, b, last);
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_vector(int len, bit zero_b);
    for (int i = 0; i < len; i++)
      send_pair(rand_elem(), zero_b ? 16'sd0 : rand_elem(), i == len - 1);
  endtask

  initial begin
    int sent;
    int len;
    burst_left = 0;
    idle_cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, every mode, zero norm, bad selector
    send_pair(16'sh7FFF, 16'sh7FFF, 1);
    send_pair(16'sh7FFF, -16'sh8000, 1);
    send_pair(16'sd0, 16'sd5, 1);
    write_mode(ModeEuclid);
    send_pair(16'sh7FFF, -16'sh8000, 0);
    send_pair(-16'sh8000, 16'sh7FFF, 1);
    send_pair(16'sd1, 16'sd0, 1);
    write_mode(ModeNormSq);
    send_pair(16'sh1234, -16'sh1234, 1);
    send_pair(16'sd3, 16'sd0, 1);
    send_pair(-16'sd7, 16'sd9, 1);
    write_mode(2'd3);
    send_pair(16'sd100, 16'sd200, 1);
    write_mode(ModeEuclid);
    send_vector(MaxVecLen + 3, 0); // too many pairs
    sent = 10 + int'(MaxVecLen) + 3;

    // Random vectors, mode changes between phases
    while (sent < 650) begin
      if ($urandom_range(0, 7) == 0) begin
        item_if.valid <= 0;
        burst_left = 0;
        write_mode(2'($urandom_range(0, 3)));
      end
      case ($urandom_range(0, 9))
        0: len = $urandom_range(MaxVecLen - 2, MaxVecLen + 2);
        default: len = $urandom_range(1, 12);
      endcase
      send_vector(len, $urandom_range(0, 19) == 0);
      sent += len;
    end
    item_if.valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
